FILE: design/prefix_cache_server_registry_top_assert.svh
// Assertion macros used by the checker file pcsr_chk.sv.
`ifndef PREFIX_CACHE_SERVER_REGISTRY_TOP_ASSERT_SVH
`define PREFIX_CACHE_SERVER_REGISTRY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PCSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PCSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pcsr_pkg.sv
`default_nettype none
package pcsr_pkg;

  localparam int CMD_W    = 4;
  localparam int SRV_W    = 4;
  localparam int LIMIT_W  = 32;
  localparam int HASH_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int DEPTH_W  = 9;

  localparam logic [CMD_W-1:0] CMD_PREREG     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTERED = 4'd1;
  localparam logic [CMD_W-1:0] CMD_DOWN       = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SET_ACC    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_INC        = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEC        = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ADD_BLOCK  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_ROUTE      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SNAPSHOT   = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    SCAN_CLEAR,
    SCAN_DOWN,
    SCAN_FIND
  } scan_mode_t;

  typedef struct packed {
    logic       rdy;
    logic       exec;
    logic       clear_query;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       route_apply;
    logic       add_apply;
    logic       down_apply;
    logic       load_out;
    logic       out_all;
    logic       out_depth;
  } ctl_t;

  typedef struct packed {
    logic             accepted;
    logic [CMD_W-1:0] cmd;
    logic             first;
    logic             lastq;
    logic             known;
    logic             route_live;
    logic             scan_done;
    logic             out_free;
    logic             emit_last;
  } stat_t;

endpackage
`default_nettype wire

FILE: design/pcsr_if.sv
`default_nettype none
interface pcsr_req_if;
  logic                         valid;
  logic                         ready;
  logic [pcsr_pkg::CMD_W-1:0]   cmd;
  logic [pcsr_pkg::SRV_W-1:0]   server;
  logic [pcsr_pkg::LIMIT_W-1:0] in_flight_limit;
  logic                         accepting;
  logic [pcsr_pkg::HASH_W-1:0]  block_hash;
  logic                         first_of_query;
  logic                         last_of_query;

  modport source (output valid, cmd, server, in_flight_limit, accepting, block_hash,
                  first_of_query, last_of_query, input ready);
  modport sink (input valid, cmd, server, in_flight_limit, accepting, block_hash,
                first_of_query, last_of_query, output ready);
endinterface

interface pcsr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pcsr_pkg::STATUS_W-1:0] status;
  logic [pcsr_pkg::SRV_W-1:0]    slot;
  logic                          known;
  logic                          healthy;
  logic                          accepting_tasks;
  logic [pcsr_pkg::LIMIT_W-1:0]  in_flight;
  logic [pcsr_pkg::LIMIT_W-1:0]  max_in_flight;
  logic [pcsr_pkg::COUNT_W-1:0]  cached_count;
  logic [pcsr_pkg::DEPTH_W-1:0]  prefix_depth;
  logic                          down_notify;
  logic                          last;

  modport source (output valid, status, slot, known, healthy, accepting_tasks, in_flight,
                  max_in_flight, cached_count, prefix_depth, down_notify, last,
                  input ready);
  modport sink (input valid, status, slot, known, healthy, accepting_tasks, in_flight,
                max_in_flight, cached_count, prefix_depth, down_notify, last,
                output ready);
endinterface
`default_nettype wire

FILE: design/pcsr_ctrl.sv
`default_nettype none
module pcsr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  pcsr_pkg::stat_t stat,
  output pcsr_pkg::ctl_t  ctl
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_ROUTE_CHK,
    S_SCAN,
    S_APPLY,
    S_ROUTE_END,
    S_EMIT_ONE,
    S_EMIT_ALL
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl = '0;
    ctl.scan_mode = pcsr_pkg::SCAN_FIND;
    state_next = state;
    case (state)
      S_INIT: begin
        // wait for the table clearing pass
        if (stat.scan_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl.rdy = 1'b1;
        if (stat.accepted) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd)
          pcsr_pkg::CMD_PREREG, pcsr_pkg::CMD_REGISTERED, pcsr_pkg::CMD_SET_ACC,
          pcsr_pkg::CMD_INC, pcsr_pkg::CMD_DEC: begin
            ctl.exec = 1'b1;
            state_next = S_EMIT_ONE;
          end
          pcsr_pkg::CMD_DOWN: begin
            if (stat.known) begin
              ctl.scan_start = 1'b1;
              ctl.scan_mode = pcsr_pkg::SCAN_DOWN;
              state_next = S_SCAN;
            end else begin
              ctl.exec = 1'b1;
              state_next = S_EMIT_ONE;
            end
          end
          pcsr_pkg::CMD_ADD_BLOCK: begin
            if (stat.known) begin
              ctl.scan_start = 1'b1;
              state_next = S_SCAN;
            end else begin
              ctl.exec = 1'b1;
              state_next = S_EMIT_ONE;
            end
          end
          pcsr_pkg::CMD_ROUTE: begin
            ctl.clear_query = stat.first;
            state_next = S_ROUTE_CHK;
          end
          pcsr_pkg::CMD_SNAPSHOT: begin
            state_next = S_EMIT_ALL;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_ROUTE_CHK: begin
        if (stat.route_live) begin
          ctl.scan_start = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_ROUTE_END;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        case (stat.cmd)
          pcsr_pkg::CMD_DOWN: begin
            ctl.down_apply = 1'b1;
            state_next = S_EMIT_ONE;
          end
          pcsr_pkg::CMD_ADD_BLOCK: begin
            ctl.add_apply = 1'b1;
            state_next = S_EMIT_ONE;
          end
          default: begin
            ctl.route_apply = 1'b1;
            state_next = S_ROUTE_END;
          end
        endcase
      end
      S_ROUTE_END: begin
        state_next = stat.lastq ? S_EMIT_ALL : S_IDLE;
      end
      S_EMIT_ONE: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT_ALL: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          ctl.out_all = 1'b1;
          ctl.out_depth = (stat.cmd == pcsr_pkg::CMD_ROUTE);
          if (stat.emit_last) begin
            // a finished query is dropped once its results are out
            ctl.clear_query = (stat.cmd == pcsr_pkg::CMD_ROUTE);
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/pcsr_dp.sv
`default_nettype none
module pcsr_dp #(
  parameter int NS  = 16,
  parameter int TE  = 1024,
  parameter int MQD = 256
) (
  input  logic            clk,
  input  logic            rst,
  pcsr_req_if.sink        req,
  pcsr_rsp_if.source      rsp,
  input  pcsr_pkg::ctl_t  ctl,
  output pcsr_pkg::stat_t stat
);

  localparam int AW = $clog2(TE);
  localparam int EW = (NS > 1) ? $clog2(NS) : 1;
  localparam int QW = $clog2(MQD + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TE - 1);

  typedef logic [NS-1:0] mask_t;

  // latched command
  logic [pcsr_pkg::CMD_W-1:0]   cmd_q;
  logic [pcsr_pkg::SRV_W-1:0]   srv_q;
  logic [pcsr_pkg::LIMIT_W-1:0] lim_q;
  logic                         accf_q;
  logic [pcsr_pkg::HASH_W-1:0]  hash_q;
  logic                         first_q;
  logic                         lastq_q;

  // per-server state
  mask_t                        known_f;
  mask_t                        healthy_f;
  mask_t                        acc_f;
  logic [pcsr_pkg::LIMIT_W-1:0] infl     [NS];
  logic [pcsr_pkg::LIMIT_W-1:0] lim_r    [NS];
  logic [pcsr_pkg::COUNT_W-1:0] bcnt     [NS];

  // block table
  mask_t                       mask_mem [TE];
  logic [pcsr_pkg::HASH_W-1:0] hash_mem [TE];

  logic                        scan_run;
  logic [AW-1:0]               scan_addr;
  pcsr_pkg::scan_mode_t        scan_mode;
  logic                        ev_valid;
  logic [AW-1:0]               ev_idx;
  mask_t                       rd_mask;
  logic [pcsr_pkg::HASH_W-1:0] rd_hash;

  logic          hit;
  logic [AW-1:0] hit_idx;
  mask_t         hit_mask;
  logic          free_hit;
  logic [AW-1:0] free_idx;

  // route query
  mask_t                        cand;
  logic [pcsr_pkg::DEPTH_W-1:0] depth [NS];
  logic [QW-1:0]                qpos;
  logic                         qstop;

  logic [EW-1:0]                 emit_idx;
  logic [pcsr_pkg::STATUS_W-1:0] res_status;
  logic                          res_notify;

  logic          accepted;
  logic          srv_in;
  logic [EW-1:0] srv_idx;
  logic          srv_known;
  mask_t         srv_bit;
  logic          scan_done;
  logic          emit_last;
  logic          add_counts;
  logic          mw_en;
  logic          hw_en;
  logic [AW-1:0] mw_addr;
  mask_t         mw_data;
  mask_t         route_mask;
  logic [QW-1:0] qpos_inc;
  logic [EW-1:0] sel_idx;
  logic          sel_in;

  assign accepted  = req.valid && ctl.rdy;
  assign req.ready = ctl.rdy;

  assign srv_in    = (32'(srv_q) < 32'(NS));
  assign srv_idx   = EW'(srv_q);
  assign srv_known = srv_in && known_f[srv_idx];
  assign srv_bit   = srv_in ? (mask_t'(1) << srv_idx) : '0;
  assign scan_done = ev_valid && (ev_idx == LAST_ADDR);
  assign emit_last = (32'(emit_idx) == 32'(NS - 1));
  assign add_counts = hit ? ((hit_mask & srv_bit) == '0) : free_hit;
  assign route_mask = (qpos == '0) ? hit_mask : (cand & hit_mask);
  assign qpos_inc   = qpos + QW'(1);

  always_comb begin
    stat.accepted   = accepted;
    stat.cmd        = cmd_q;
    stat.first      = first_q;
    stat.lastq      = lastq_q;
    stat.known      = srv_known;
    stat.route_live = !qstop && (32'(qpos) < 32'(MQD));
    stat.scan_done  = scan_done;
    stat.out_free   = !rsp.valid || rsp.ready;
    stat.emit_last  = emit_last;
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      cmd_q   <= req.cmd;
      srv_q   <= req.server;
      lim_q   <= req.in_flight_limit;
      accf_q  <= req.accepting;
      hash_q  <= req.block_hash;
      first_q <= req.first_of_query;
      lastq_q <= req.last_of_query;
    end
  end

  // Sweep the table one entry a cycle; read data arrives in the cycle after its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run  <= 1'b1;
      scan_addr <= '0;
      scan_mode <= pcsr_pkg::SCAN_CLEAR;
      ev_valid  <= 1'b0;
    end else begin
      ev_valid <= scan_run;
      if (ctl.scan_start) begin
        scan_run  <= 1'b1;
        scan_addr <= '0;
        scan_mode <= ctl.scan_mode;
      end else if (scan_run) begin
        if (scan_addr == LAST_ADDR) begin
          scan_run <= 1'b0;
        end else begin
          scan_addr <= scan_addr + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx  <= scan_addr;
    rd_mask <= mask_mem[scan_addr];
    rd_hash <= hash_mem[scan_addr];
  end

  always_comb begin
    mw_en   = 1'b0;
    hw_en   = 1'b0;
    mw_addr = ev_idx;
    mw_data = '0;
    if (ev_valid && (scan_mode == pcsr_pkg::SCAN_CLEAR || scan_mode == pcsr_pkg::SCAN_DOWN)) begin
      mw_en   = 1'b1;
      mw_data = (scan_mode == pcsr_pkg::SCAN_DOWN) ? (rd_mask & ~srv_bit) : '0;
    end else if (ctl.add_apply) begin
      if (hit) begin
        mw_en   = add_counts;
        mw_addr = hit_idx;
        mw_data = hit_mask | srv_bit;
      end else if (free_hit) begin
        mw_en   = 1'b1;
        hw_en   = 1'b1;
        mw_addr = free_idx;
        mw_data = srv_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mw_en) begin
      mask_mem[mw_addr] <= mw_data;
    end
    if (hw_en) begin
      hash_mem[mw_addr] <= hash_q;
    end
  end

  // An entry is in use exactly when its mask is nonzero.
  always_ff @(posedge clk) begin
    if (rst || ctl.scan_start) begin
      hit      <= 1'b0;
      free_hit <= 1'b0;
    end else if (ev_valid && scan_mode == pcsr_pkg::SCAN_FIND) begin
      if ((rd_mask != '0) && (rd_hash == hash_q) && !hit) begin
        hit      <= 1'b1;
        hit_idx  <= ev_idx;
        hit_mask <= rd_mask;
      end
      if ((rd_mask == '0) && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= ev_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known_f   <= '0;
      healthy_f <= '0;
      acc_f     <= '1;
      for (int s = 0; s < NS; s++) begin
        infl[s]  <= '0;
        lim_r[s] <= '0;
        bcnt[s]  <= '0;
      end
    end else begin
      if (ctl.exec && srv_in) begin
        case (cmd_q)
          pcsr_pkg::CMD_PREREG: begin
            known_f[srv_idx] <= 1'b1;
          end
          pcsr_pkg::CMD_REGISTERED: begin
            if (srv_known) begin
              healthy_f[srv_idx] <= 1'b1;
              lim_r[srv_idx]     <= lim_q;
            end
          end
          pcsr_pkg::CMD_SET_ACC: begin
            if (srv_known) begin
              acc_f[srv_idx] <= accf_q;
            end
          end
          pcsr_pkg::CMD_INC: begin
            if (srv_known && infl[srv_idx] != '1) begin
              infl[srv_idx] <= infl[srv_idx] + 32'd1;
            end
          end
          pcsr_pkg::CMD_DEC: begin
            if (srv_known && infl[srv_idx] != '0) begin
              infl[srv_idx] <= infl[srv_idx] - 32'd1;
            end
          end
          default: begin
          end
        endcase
      end
      if (ctl.down_apply) begin
        healthy_f[srv_idx] <= 1'b0;
        bcnt[srv_idx]      <= '0;
      end
      if (ctl.add_apply && add_counts) begin
        bcnt[srv_idx] <= bcnt[srv_idx] + pcsr_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      res_status <= pcsr_pkg::ST_OK;
      res_notify <= 1'b0;
    end else begin
      if (ctl.exec) begin
        if (cmd_q == pcsr_pkg::CMD_PREREG) begin
          res_status <= srv_in ? pcsr_pkg::ST_OK : pcsr_pkg::ST_UNKNOWN;
        end else begin
          res_status <= srv_known ? pcsr_pkg::ST_OK : pcsr_pkg::ST_UNKNOWN;
        end
      end
      if (ctl.down_apply) begin
        res_notify <= 1'b1;
      end
      if (ctl.add_apply && !hit && !free_hit) begin
        res_status <= pcsr_pkg::ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_query) begin
      cand  <= '0;
      qpos  <= '0;
      qstop <= 1'b0;
      for (int s = 0; s < NS; s++) begin
        depth[s] <= '0;
      end
    end else if (ctl.route_apply) begin
      if (!hit) begin
        qstop <= 1'b1;
      end else begin
        cand <= route_mask;
        if (route_mask == '0) begin
          qstop <= 1'b1;
        end else begin
          qpos <= qpos_inc;
          for (int s = 0; s < NS; s++) begin
            if (route_mask[s]) begin
              depth[s] <= pcsr_pkg::DEPTH_W'(qpos_inc);
            end
          end
        end
      end
    end
  end

  assign sel_idx = ctl.out_all ? emit_idx : srv_idx;
  assign sel_in  = ctl.out_all || srv_in;

  always_ff @(posedge clk) begin
    if (accepted) begin
      emit_idx <= '0;
    end else if (ctl.load_out && ctl.out_all) begin
      emit_idx <= emit_idx + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ctl.load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      rsp.status          <= ctl.out_all ? pcsr_pkg::ST_OK : res_status;
      rsp.slot            <= ctl.out_all ? pcsr_pkg::SRV_W'(emit_idx) : srv_q;
      rsp.known           <= sel_in && known_f[sel_idx];
      rsp.healthy         <= sel_in && healthy_f[sel_idx];
      rsp.accepting_tasks <= sel_in && acc_f[sel_idx];
      rsp.in_flight       <= sel_in ? infl[sel_idx] : '0;
      rsp.max_in_flight   <= sel_in ? lim_r[sel_idx] : '0;
      rsp.cached_count    <= sel_in ? bcnt[sel_idx] : '0;
      rsp.prefix_depth    <= (ctl.out_all && ctl.out_depth) ? depth[sel_idx] : '0;
      rsp.down_notify     <= !ctl.out_all && res_notify;
      rsp.last            <= ctl.out_all ? emit_last : 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: design/prefix_cache_server_registry_top.sv
// Channel  Role  Modport      Payload
// req      in    pcsr_req_if  cmd, server, in_flight_limit, accepting, block_hash, first/last
// rsp      out   pcsr_rsp_if  status, slot, flags, counts, prefix_depth, down_notify, last
//
// One transaction at a time: req.ready is high only while the sequencer idles.
// Slot commands and unknown-server answers go from dispatch to the emit step, which
// loads the result when rsp is free. Add block and mark down sweep the table one entry
// a cycle, then apply and emit; a live route element sweeps, then applies and frees req.
// Snapshot and a last route element load NUM_SERVERS results, one per free rsp cycle.
// rst starts a clearing pass over all TABLE_ENTRIES entries with req.ready low; a stalled rsp
// holds its result and the next one waits for it.
`default_nettype none
module prefix_cache_server_registry_top #(
  parameter int NUM_SERVERS     = 16,
  parameter int TABLE_ENTRIES   = 1024,
  parameter int MAX_QUERY_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  pcsr_req_if.sink   req,
  pcsr_rsp_if.source rsp
);

  // command strobes from the sequencer, status back from the datapath
  pcsr_pkg::ctl_t  ctl;
  pcsr_pkg::stat_t stat;

  // sequencer: decodes the held transaction and walks scan, apply and emit steps
  pcsr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // datapath: slot registers, block table memories, query state, result register
  pcsr_dp #(
    .NS  (NUM_SERVERS),
    .TE  (TABLE_ENTRIES),
    .MQD (MAX_QUERY_DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .ctl  (ctl),
    .stat (stat)
  );

endmodule
`default_nettype wire

FILE: design/pcsr_chk.sv
`default_nettype none
`include "prefix_cache_server_registry_top_assert.svh"
module pcsr_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [pcsr_pkg::STATUS_W-1:0] status,
  input logic                          healthy,
  input logic [pcsr_pkg::COUNT_W-1:0]  cached_count,
  input logic [pcsr_pkg::DEPTH_W-1:0]  prefix_depth,
  input logic                          down_notify,
  input logic                          last
);

  `PCSR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
  `PCSR_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "req taken twice")
  `PCSR_ASSERT_NOW(a_down_result, rsp_valid && down_notify, last && status == pcsr_pkg::ST_OK && !healthy && cached_count == '0, "bad down result")
  `PCSR_ASSERT_NOW(a_err_single, rsp_valid && status != pcsr_pkg::ST_OK, last && prefix_depth == '0, "error result not single")

endmodule

bind prefix_cache_server_registry_top pcsr_chk u_pcsr_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .healthy      (rsp.healthy),
  .cached_count (rsp.cached_count),
  .prefix_depth (rsp.prefix_depth),
  .down_notify  (rsp.down_notify),
  .last         (rsp.last)
);
`default_nettype wire

FILE: sim/prefix_cache_server_registry_top_tb.sv
`default_nettype none
module prefix_cache_server_registry_top_tb;

  localparam int NSRV = 16;
  localparam int NENT = 1024;
  localparam int MAXQ = 256;
  // random rounds; with directed items and the long query this gives about 400 items
  localparam int RANDOM_ITEMS = 75;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef logic [pcsr_pkg::CMD_W-1:0] cmd_code_t;
  localparam cmd_code_t CMD_UNUSED_LO = 4'd9;
  localparam cmd_code_t CMD_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [pcsr_pkg::CMD_W-1:0]   cmd;
    logic [pcsr_pkg::SRV_W-1:0]   server;
    logic [pcsr_pkg::LIMIT_W-1:0] limit;
    logic                         acc;
    logic [pcsr_pkg::HASH_W-1:0]  hash;
    logic                         first;
    logic                         lastq;
  } cmd_item_t;

  typedef struct packed {
    logic [pcsr_pkg::STATUS_W-1:0] status;
    logic [pcsr_pkg::SRV_W-1:0]    slot;
    logic                          known;
    logic                          healthy;
    logic                          acc;
    logic [pcsr_pkg::LIMIT_W-1:0]  in_flight;
    logic [pcsr_pkg::LIMIT_W-1:0]  max_in_flight;
    logic [pcsr_pkg::COUNT_W-1:0]  cached;
    logic [pcsr_pkg::DEPTH_W-1:0]  depth;
    logic                          notify;
    logic                          last;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  pcsr_req_if req();
  pcsr_rsp_if rsp();

  prefix_cache_server_registry_top dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // Registry shadow state.
  logic                         srv_known [NSRV];
  logic                         srv_healthy [NSRV];
  logic                         srv_acc [NSRV];
  logic [pcsr_pkg::LIMIT_W-1:0] srv_count [NSRV];
  logic [pcsr_pkg::LIMIT_W-1:0] srv_limit [NSRV];
  int                           srv_blocks [NSRV];
  logic [pcsr_pkg::HASH_W-1:0]  tbl_hash [NENT];
  logic [NSRV-1:0]              tbl_mask [NENT];
  logic                         tbl_valid [NENT];
  logic [NSRV-1:0]              cand_mask;
  int                           hit_depth [NSRV];
  logic                         q_stopped;
  int                           q_pos;

  cmd_item_t    pending_cmds[$];
  slot_report_t expected_reports[$];
  logic [pcsr_pkg::HASH_W-1:0] hash_pool[$];
  int  errors = 0;
  bit  hold_sender = 1'b0;
  bit  req_taken = 1'b0;
  longint cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void add_cmd(cmd_item_t it);
    pending_cmds.insert(pending_cmds.size(), it);
  endfunction

  function automatic void add_report(slot_report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic void add_hash(logic [pcsr_pkg::HASH_W-1:0] h);
    hash_pool.insert(hash_pool.size(), h);
  endfunction

  function automatic slot_report_t describe_slot(logic [1:0] st, int s, int d, logic nt,
                                                 logic lst);
    slot_report_t r;
    r.status = st;
    r.slot = s[pcsr_pkg::SRV_W-1:0];
    r.known = srv_known[s];
    r.healthy = srv_healthy[s];
    r.acc = srv_acc[s];
    r.in_flight = srv_count[s];
    r.max_in_flight = srv_limit[s];
    r.cached = srv_blocks[s][pcsr_pkg::COUNT_W-1:0];
    r.depth = d[pcsr_pkg::DEPTH_W-1:0];
    r.notify = nt;
    r.last = lst;
    return r;
  endfunction

  function automatic int lookup_block(logic [pcsr_pkg::HASH_W-1:0] h);
    for (int i = 0; i < NENT; i++)
      if (tbl_valid[i] && tbl_hash[i] == h) return i;
    return -1;
  endfunction

  function automatic void reset_query();
    cand_mask = '0;
    q_stopped = 1'b0;
    q_pos = 0;
    for (int s = 0; s < NSRV; s++) hit_depth[s] = 0;
  endfunction

  function automatic void reset_registry();
    for (int s = 0; s < NSRV; s++) begin
      srv_known[s] = 0; srv_healthy[s] = 0; srv_acc[s] = 1;
      srv_count[s] = 0; srv_limit[s] = 0; srv_blocks[s] = 0;
    end
    for (int i = 0; i < NENT; i++) begin
      tbl_hash[i] = '0; tbl_mask[i] = '0; tbl_valid[i] = 0;
    end
    reset_query();
  endfunction

  function automatic void queue_all_slots(bit with_depth);
    for (int s = 0; s < NSRV; s++)
      add_report(describe_slot(pcsr_pkg::ST_OK, s, with_depth ? hit_depth[s] : 0, 0,
                               s == NSRV - 1));
  endfunction

  // Advance the shadow registry by one accepted command and queue its reports.
  function automatic void apply_command(cmd_item_t it);
    int s = it.server;
    int e;
    logic [1:0] st = pcsr_pkg::ST_OK;
    logic nt = 0;
    if (it.cmd == pcsr_pkg::CMD_ROUTE) begin
      if (it.first) reset_query();
      if (!q_stopped && q_pos < MAXQ) begin
        e = lookup_block(it.hash);
        if (e < 0) q_stopped = 1;
        else begin
          cand_mask = (q_pos == 0) ? tbl_mask[e] : (cand_mask & tbl_mask[e]);
          if (cand_mask == 0) q_stopped = 1;
          else begin
            q_pos++;
            for (int k = 0; k < NSRV; k++) if (cand_mask[k]) hit_depth[k] = q_pos;
          end
        end
      end
      if (it.lastq) begin
        queue_all_slots(1);
        reset_query();
      end
      return;
    end
    if (it.cmd == pcsr_pkg::CMD_SNAPSHOT) begin
      queue_all_slots(0);
      return;
    end
    if (it.cmd > pcsr_pkg::CMD_SNAPSHOT) return;
    if (it.cmd == pcsr_pkg::CMD_PREREG) srv_known[s] = 1;
    else if (!srv_known[s]) st = pcsr_pkg::ST_UNKNOWN;
    else case (it.cmd)
      pcsr_pkg::CMD_REGISTERED: begin
        srv_healthy[s] = 1; srv_limit[s] = it.limit;
      end
      pcsr_pkg::CMD_DOWN: begin
        srv_healthy[s] = 0;
        for (int i = 0; i < NENT; i++) if (tbl_valid[i]) begin
          tbl_mask[i][s] = 0;
          if (tbl_mask[i] == 0) tbl_valid[i] = 0;
        end
        srv_blocks[s] = 0;
        nt = 1;
      end
      pcsr_pkg::CMD_SET_ACC: srv_acc[s] = it.acc;
      pcsr_pkg::CMD_INC: if (srv_count[s] != '1) srv_count[s]++;
      pcsr_pkg::CMD_DEC: if (srv_count[s] != 0) srv_count[s]--;
      default: begin
        e = lookup_block(it.hash);
        if (e < 0) begin
          for (int i = 0; i < NENT; i++) if (!tbl_valid[i]) begin
            e = i; break;
          end
          if (e < 0) st = pcsr_pkg::ST_FULL;
          else begin
            tbl_valid[e] = 1; tbl_hash[e] = it.hash; tbl_mask[e] = '0;
            tbl_mask[e][s] = 1; srv_blocks[s]++;
          end
        end else if (!tbl_mask[e][s]) begin
          tbl_mask[e][s] = 1; srv_blocks[s]++;
        end
      end
    endcase
    add_report(describe_slot(st, s, 0, nt, 1));
  endfunction

  function automatic cmd_item_t make_cmd(cmd_code_t c, int s);
    cmd_item_t it;
    it.cmd = c;
    it.server = s[pcsr_pkg::SRV_W-1:0];
    it.limit = $urandom;
    it.acc = 1'($urandom_range(0, 1));
    it.hash = {$urandom, $urandom};
    it.first = 1'($urandom_range(0, 1));
    it.lastq = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [pcsr_pkg::HASH_W-1:0] pick_hash();
    if (hash_pool.size() == 0 || $urandom_range(0, 5) == 0) begin
      add_hash({$urandom, $urandom});
      return hash_pool[hash_pool.size() - 1];
    end
    return hash_pool[$urandom_range(0, hash_pool.size() - 1)];
  endfunction

  // Push one route query: mostly cached hashes, sometimes a stray miss.
  function automatic void push_query(int len);
    cmd_item_t it;
    for (int k = 0; k < len; k++) begin
      it = make_cmd(pcsr_pkg::CMD_ROUTE, $urandom_range(0, NSRV - 1));
      it.hash = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : pick_hash();
      it.first = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
      it.lastq = (k == len - 1);
      add_cmd(it);
    end
  endfunction

  // Driver: bursts of random length, random gaps between them.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      {req.cmd, req.server, req.in_flight_limit, req.accepting, req.block_hash,
       req.first_of_query, req.last_of_query} <= '0;
    end else begin
      if (req.valid && !req_taken) begin
        // hold the transaction until it is taken
      end else if (!hold_sender && pending_cmds.size() > 0 &&
                   (gap_left == 0 || burst_left > 0)) begin
        {req.cmd, req.server, req.in_flight_limit, req.accepting, req.block_hash,
         req.first_of_query, req.last_of_query} <= pending_cmds[0];
        req.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else burst_left <= burst_left - 1;
      end else begin
        req.valid <= 1'b0;
        if (gap_left > 0 && burst_left == 0) gap_left <= gap_left - 1;
        else if (burst_left > 0) burst_left <= 0;
      end
    end
  end

  // Receiver stall pattern: long stall-free runs interleaved with stalls.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 97;
    if (stall_phase < 40) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 2) != 0);
  end

  // Predict on the accepted request, then check the accepted response.
  always @(posedge clk) begin
    slot_report_t got;
    slot_report_t want;
    cmd_item_t    taken;
    cycles++;
    req_taken = 1'b0;
    if (!rst) begin
      if (req.valid && req.ready) begin
        taken = pending_cmds.pop_front();
        apply_command(taken);
        req_taken = 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.slot, rsp.known, rsp.healthy, rsp.accepting_tasks,
               rsp.in_flight, rsp.max_in_flight, rsp.cached_count, rsp.prefix_depth,
               rsp.down_notify, rsp.last};
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected %h actual %h", $time, want, got);
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("prefix_cache_server_registry_top: mismatch");
      $finish;
    end
  end

  initial begin
    cmd_item_t it;
    int r;
    reset_registry();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: unknown slot, prereg twice, limits at the extremes, in-flight edges.
    add_cmd(make_cmd(pcsr_pkg::CMD_INC, 3));
    add_cmd(make_cmd(pcsr_pkg::CMD_PREREG, 0));
    add_cmd(make_cmd(pcsr_pkg::CMD_PREREG, 15));
    it = make_cmd(pcsr_pkg::CMD_REGISTERED, 0); it.limit = '1; add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_REGISTERED, 15); it.limit = '0; add_cmd(it);
    add_cmd(make_cmd(pcsr_pkg::CMD_PREREG, 0));
    add_cmd(make_cmd(pcsr_pkg::CMD_DEC, 0));
    add_cmd(make_cmd(pcsr_pkg::CMD_INC, 0));
    it = make_cmd(pcsr_pkg::CMD_SET_ACC, 15); it.acc = 0; add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_SET_ACC, 15); it.acc = 1; add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_ADD_BLOCK, 0); it.hash = '1; add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_ADD_BLOCK, 0); it.hash = '1; add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_ADD_BLOCK, 15); it.hash = '1; add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_ADD_BLOCK, 15); it.hash = '0; add_cmd(it);
    // route: hit both, narrow to 15, then a miss stops the query; element after finish restarts
    it = make_cmd(pcsr_pkg::CMD_ROUTE, 0); it.hash = '1; it.first = 1; it.lastq = 0;
    add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_ROUTE, 0); it.hash = '0; it.first = 0; it.lastq = 0;
    add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_ROUTE, 0); it.hash = 64'h5; it.first = 0; it.lastq = 1;
    add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_ROUTE, 0); it.hash = '1; it.first = 0; it.lastq = 1;
    add_cmd(it);
    add_cmd(make_cmd(pcsr_pkg::CMD_SNAPSHOT, 0));
    add_cmd(make_cmd(pcsr_pkg::CMD_DOWN, 15));
    add_cmd(make_cmd(pcsr_pkg::CMD_DOWN, 7));
    add_cmd(make_cmd(CMD_UNUSED_LO, 0));
    add_cmd(make_cmd(CMD_UNUSED_HI, 15));
    add_cmd(make_cmd(pcsr_pkg::CMD_SNAPSHOT, 0));
    add_hash('1);

    // Pause until every expected result has drained.
    wait (pending_cmds.size() == 0);
    hold_sender = 1;
    wait (expected_reports.size() == 0);
    @(posedge clk);
    hold_sender = 0;

    for (int s = 0; s < NSRV; s++) add_cmd(make_cmd(pcsr_pkg::CMD_PREREG, s));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        it = make_cmd(pcsr_pkg::CMD_ADD_BLOCK, $urandom_range(0, NSRV - 1));
        it.hash = pick_hash();
        add_cmd(it);
      end else if (r < 45) begin
        push_query($urandom_range(1, 5));
      end else if (r < 48) begin
        add_cmd(make_cmd(pcsr_pkg::CMD_DOWN, $urandom_range(0, NSRV - 1)));
      end else if (r < 52) begin
        add_cmd(make_cmd(pcsr_pkg::CMD_SNAPSHOT, $urandom_range(0, NSRV - 1)));
      end else if (r < 54) begin
        add_cmd(make_cmd(cmd_code_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                         $urandom_range(0, 15)));
      end else if (r < 58) begin
        add_cmd(make_cmd(pcsr_pkg::CMD_ROUTE, $urandom_range(0, 15)));
      end else begin
        add_cmd(make_cmd(cmd_code_t'($urandom_range(pcsr_pkg::CMD_PREREG, pcsr_pkg::CMD_DEC)),
                         $urandom_range(0, 15)));
      end
    end
    // Long query past the depth limit on a block added for server 1.
    it = make_cmd(pcsr_pkg::CMD_PREREG, 1); add_cmd(it);
    it = make_cmd(pcsr_pkg::CMD_ADD_BLOCK, 1); it.hash = 64'hABCD; add_cmd(it);
    for (int k = 0; k < MAXQ + 3; k++) begin
      it = make_cmd(pcsr_pkg::CMD_ROUTE, 0); it.hash = 64'hABCD;
      it.first = (k == 0); it.lastq = (k == MAXQ + 2);
      add_cmd(it);
    end
    add_cmd(make_cmd(pcsr_pkg::CMD_SNAPSHOT, 0));

    wait (pending_cmds.size() == 0 && !req.valid);
    wait (expected_reports.size() == 0);
    repeat (2 * NENT + 50) @(posedge clk);
    if (errors == 0 && expected_reports.size() == 0)
      $display("prefix_cache_server_registry_top: match");
    else
      $display("prefix_cache_server_registry_top: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
